// ===== rtl/core/dnld_pkg.sv =====
// ----------------------------------------------------------------------------
// dnld_pkg
// Shared types and constants for the DNS name label decoder.
// ----------------------------------------------------------------------------
package dnld_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 2;

    localparam logic [ByteW-1:0] CharUpperA = 8'h41;  // 'A'
    localparam logic [ByteW-1:0] CharUpperZ = 8'h5A;  // 'Z'
    localparam logic [ByteW-1:0] CharDot    = 8'h2E;  // '.'
    localparam logic [ByteW-1:0] CaseOffset = 8'h20;  // 'a' - 'A'

    typedef enum logic [KindW-1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } dnld_kind_t;

    // one registered input byte
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
    } dnld_item_t;

    // decoded result of one input byte
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] ch;
        dnld_kind_t       kind;
        logic [ByteW-1:0] len;
    } dnld_result_t;

endpackage

// ===== rtl/core/dnld_in_reg.sv =====
// ----------------------------------------------------------------------------
// dnld_in_reg
// Input register stage: holds one accepted name byte until it is decoded.
// ----------------------------------------------------------------------------
module dnld_in_reg
    import dnld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ByteW-1:0] in_data,
    input  logic             take,      // decode stage consumes the held byte
    output dnld_item_t       item
);

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] data_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// ===== rtl/core/dnld_decode.sv =====
// ----------------------------------------------------------------------------
// dnld_decode
// Label parser: name state registers plus the per-byte decode logic.
// ----------------------------------------------------------------------------
module dnld_decode
    import dnld_pkg::*;
#(
    parameter int unsigned MAX_PATH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  dnld_item_t   item,
    input  logic         step,     // item is consumed this cycle
    output dnld_result_t res
);

    localparam logic [ByteW:0] MaxPathW = (ByteW+1)'(MAX_PATH);

    logic             in_label_reg;
    logic             in_label_next;
    logic [ByteW-1:0] remain_reg;
    logic [ByteW-1:0] remain_next;
    logic [ByteW-1:0] total_reg;
    logic [ByteW-1:0] total_next;

    logic [ByteW-1:0] folded;
    logic [ByteW:0]   sum;
    logic             overflow;
    logic [ByteW-1:0] total_inc;

    assign folded    = (item.data >= CharUpperA && item.data <= CharUpperZ)
                       ? item.data + CaseOffset : item.data;
    assign sum       = {1'b0, total_reg} + {1'b0, item.data};
    assign overflow  = (sum >= MaxPathW);
    assign total_inc = total_reg + 8'd1;

    always_comb
    begin
        in_label_next = in_label_reg;
        remain_next   = remain_reg;
        total_next    = total_reg;
        res.valid     = 1'b0;
        res.ch        = '0;
        res.kind      = KIND_CHAR;
        res.len       = '0;
        priority if (in_label_reg)
        begin
            // label character
            total_next    = total_inc;
            remain_next   = remain_reg - 8'd1;
            in_label_next = (remain_reg != 8'd1);
            res.valid     = item.valid;
            res.ch        = folded;
            res.len       = total_inc;
        end
        else if (item.data == '0)
        begin
            // end of name
            in_label_next = 1'b0;
            remain_next   = '0;
            total_next    = '0;
            res.valid     = item.valid;
            res.kind      = KIND_END;
            res.len       = total_reg;
        end
        else if (overflow)
        begin
            in_label_next = 1'b0;
            remain_next   = '0;
            total_next    = '0;
            res.valid     = item.valid;
            res.kind      = KIND_ERROR;
        end
        else
        begin
            // new label; separator dot ahead of all but the first
            in_label_next = 1'b1;
            remain_next   = item.data;
            if (total_reg != '0)
            begin
                total_next = total_inc;
                res.valid  = item.valid;
                res.ch     = CharDot;
                res.len    = total_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_label_reg <= 1'b0;
            remain_reg   <= '0;
            total_reg    <= '0;
        end
        else if (step)
        begin
            in_label_reg <= in_label_next;
            remain_reg   <= remain_next;
            total_reg    <= total_next;
        end
    end

endmodule

// ===== rtl/core/dnld_out_reg.sv =====
// ----------------------------------------------------------------------------
// dnld_out_reg
// Result register: holds one decoded result until the sink takes it.
// ----------------------------------------------------------------------------
module dnld_out_reg
    import dnld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dnld_result_t     res,
    input  logic             load,
    output logic             busy,      // holds a result the sink has not taken
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2*ByteW-1:0] out_data,
    output logic [KindW-1:0] out_user
);

    logic         valid_reg;
    logic         valid_next;
    dnld_result_t res_reg;

    assign busy = valid_reg && !out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {res_reg.len, res_reg.ch};
    assign out_user  = res_reg.kind;

endmodule

// ===== rtl/core/dns_name_label_decoder.sv =====
// Path: each input byte passes the input register, then its result the result register.
// Throughput: one name byte per cycle unless a byte with a result waits on a stalled sink;
//   a byte that yields no result (first label length) still passes the decode stage.
// Reset: rst_n is asynchronous, active low; it empties both register stages
//   and returns the parser to "expecting a length byte" with zero length.
// ----------------------------------------------------------------------------
// dns_name_label_decoder
// Decodes length-prefixed DNS name labels into a lower-cased dotted stream.
// ----------------------------------------------------------------------------
module dns_name_label_decoder
    import dnld_pkg::*;
#(
    parameter int unsigned MAX_PATH = 64   // dotted length limit, 8..255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side: encoded name bytes
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ByteW-1:0]     s_axis_tdata,   // [7:0] name_byte
    // master side: decoded results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*ByteW-1:0]   m_axis_tdata,   // [7:0] out_char, [15:8] name_length
    output logic [KindW-1:0]     m_axis_tuser    // [1:0] result_kind
);

    // Pipeline: input register -> decode logic + name state -> result register.
    // The decode stage advances whenever its byte yields no result or the
    // result register can take a new value (empty, or draining this cycle).
    // A silent byte moves on even while the sink stalls; a byte with a
    // result waits, and the input register stays full until it moves.

    dnld_item_t   item;
    dnld_result_t res;
    logic         out_busy;
    logic         step;

    assign step = item.valid && (!res.valid || !out_busy);

    dnld_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .take     (step),
        .item     (item)
    );

    // State only moves on step, so a byte waiting on a full result register
    // is decoded again against unchanged state next cycle.
    dnld_decode #(
        .MAX_PATH (MAX_PATH)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .step  (step),
        .res   (res)
    );

    dnld_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .load      (step && res.valid),
        .busy      (out_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/dnld_checker.sv =====
// ----------------------------------------------------------------------------
// dnld_checker
// Port-level assertions for the DNS name label decoder, bound to the top.
// ----------------------------------------------------------------------------
module dnld_checker
    import dnld_pkg::*;
#(
    parameter int unsigned MAX_PATH = 64
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [2*ByteW-1:0] m_axis_tdata,
    input logic [KindW-1:0]   m_axis_tuser
);

    localparam logic [ByteW-1:0] MaxPathB = ByteW'(MAX_PATH);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // error results carry no character and no length
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tdata == '0)
        else $error("error result with nonzero payload");

    // a character always counts toward the length
    a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_CHAR |-> m_axis_tdata[15:8] != '0)
        else $error("character result with zero length");

    // the dot of a later label can bring the dotted length up to the limit,
    // never past it
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:8] <= MaxPathB)
        else $error("name length above limit");

    // an end result carries no character
    a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata[7:0] == '0)
        else $error("end result with nonzero character");

endmodule

bind dns_name_label_decoder dnld_checker #(
    .MAX_PATH (MAX_PATH)
) u_dnld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/dns_name_label_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_label_decoder_test
// Self-checking bench for the DNS name label decoder. Encoded names go in
// over the slave stream. A local decoder model predicts every result. Each
// result on the master stream is checked field by field against the oldest
// prediction. Runs cover directed corner cases, random names and the length
// limit, with several idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module dns_name_label_decoder_test;

    import dnld_pkg::*;

    localparam int unsigned NameLimit = 64;    // must match the DUT's MAX_PATH
    localparam int unsigned Latency   = 2;     // input transfer to result

    // one predicted or observed result
    typedef struct packed {
        logic [ByteW-1:0] ch;
        dnld_kind_t       kind;
        logic [ByteW-1:0] len;
    } name_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [ByteW-1:0]    s_axis_tdata = '0;     // [7:0] name_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [2*ByteW-1:0]  m_axis_tdata;          // [7:0] out_char, [15:8] name_length
    logic [KindW-1:0]    m_axis_tuser;          // [1:0] result_kind

    dns_name_label_decoder #(
        .MAX_PATH (NameLimit)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model state: mirrors the parser inside the block
    // ------------------------------------------------------------------
    logic             lbl_open  = 1'b0;   // next byte is a label character
    logic [ByteW-1:0] lbl_left  = '0;     // characters still due in the label
    logic [ByteW-1:0] dotted_len = '0;    // dotted length of the name so far

    name_result_t pending_results[$];     // predicted results, oldest first

    // stimulus knobs, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct  = 0;
    logic        rx_hold       = 1'b0;    // forces tready low during a hold-off

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned n_chars      = 0;
    int unsigned n_ends       = 0;
    int unsigned n_errors     = 0;
    int unsigned error_count  = 0;

    // Decode one name byte; returns 1 when the byte yields a result.
    function automatic bit decode_byte(input logic [ByteW-1:0] b, output name_result_t r);
        logic [ByteW-1:0] c;
        logic [ByteW:0]   sum;
        r = '{ch: '0, kind: KIND_CHAR, len: '0};
        if (lbl_open) begin
            c = b;
            if (c >= CharUpperA && c <= CharUpperZ)
                c = c + CaseOffset;
            dotted_len = dotted_len + 1'b1;
            lbl_left   = lbl_left - 1'b1;
            if (lbl_left == '0)
                lbl_open = 1'b0;
            r = '{ch: c, kind: KIND_CHAR, len: dotted_len};
            return 1'b1;
        end
        if (b == '0) begin
            // zero length byte closes the name
            r = '{ch: '0, kind: KIND_END, len: dotted_len};
            dotted_len = '0;
            lbl_left   = '0;
            return 1'b1;
        end
        // limit check uses the length before any dot
        sum = {1'b0, dotted_len} + {1'b0, b};
        if (sum >= NameLimit) begin
            r = '{ch: '0, kind: KIND_ERROR, len: '0};
            dotted_len = '0;
            lbl_left   = '0;
            return 1'b1;
        end
        lbl_open = 1'b1;
        lbl_left = b;
        if (dotted_len != '0) begin
            dotted_len = dotted_len + 1'b1;
            r = '{ch: CharDot, kind: KIND_CHAR, len: dotted_len};
            return 1'b1;
        end
        return 1'b0;    // first label's length byte is silent
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Slave side: offer one byte, wait for its transfer, predict result
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [ByteW-1:0] b);
        name_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (decode_byte(b, r)) begin
            pending_results.push_back(r);
            case (r.kind)
                KIND_CHAR: n_chars++;
                KIND_END:  n_ends++;
                default:   n_errors++;
            endcase
        end
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Pause the sender until all predicted results are out. A silent
    // length byte may still sit in the pipe, so allow the latency too.
    task automatic wait_for_drain();
        int unsigned waited = 0;
        while (pending_results.size() != 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (Latency + 4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_results.size()));
    endtask

    // Label characters: half letters of either case, half any byte.
    task automatic send_label(input int unsigned n);
        logic [ByteW-1:0] c;
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
                c = CharUpperA + ByteW'($urandom_range(0, 25));
                if ($urandom_range(0, 1) == 0)
                    c = c + CaseOffset;
            end
            else begin
                c = ByteW'($urandom_range(0, 255));
            end
            send_byte(c);
        end
    endtask

    // Mostly well-formed names with random content; some noise, some
    // names cut short, some labels too long for the limit.
    task automatic send_random_name();
        int unsigned pick;
        int unsigned n_lbl;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom_range(0, 255)));
            return;
        end
        n_lbl = $urandom_range(1, 4);
        for (int i = 0; i < n_lbl; i++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70)
                                              : $urandom_range(1, 12);
            send_byte(ByteW'(len));
            if (!lbl_open)
                return;     // rejected by the length limit
            if (pick < 20 && i == n_lbl - 1) begin
                send_label($urandom_range(0, len - 1));   // truncated name
                return;
            end
            send_label(len);
        end
        send_byte('0);
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_name();
    endtask

    // ------------------------------------------------------------------
    // Master side: stall at random, check every result transfer
    // ------------------------------------------------------------------
    task automatic check_result();
        name_result_t want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result ch=%02h kind=%0d len=%0d",
                                      m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8]));
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.ch)
            report_mismatch($sformatf("out_char got %02h want %02h",
                                      m_axis_tdata[7:0], want.ch));
        if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      m_axis_tuser, want.kind));
        if (m_axis_tdata[15:8] !== want.len)
            report_mismatch($sformatf("name_length got %0d want %0d",
                                      m_axis_tdata[15:8], want.len));
    endtask

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [ByteW-1:0] seq[$];
        seq = '{8'h00,                                  // empty name
                8'h01, CharUpperA, 8'h00,               // single folded letter
                8'h02, CharUpperZ, 8'h40,               // 'Z' and the byte below 'A'
                8'h01, 8'h5B, 8'h00,                    // second label, byte above 'Z'
                8'h03, 8'h00, 8'hFF, 8'h80, 8'h00,      // zero, all ones, high bit
                8'h40,                                  // first label at the limit
                8'hFF,                                  // largest length byte
                8'h02, 8'h61, 8'h7A, 8'h3E};            // sum reaches the limit
        foreach (seq[i])
            send_byte(seq[i]);
        go_idle();
        wait_for_drain();
    endtask

    // Long labels that land just below, on, or over the limit.
    task automatic test_length_limit();
        int unsigned first_len;
        send_byte(8'd63);                 // longest legal first label
        send_label(63);
        send_byte(8'd1);                  // any further label overflows
        repeat (5) begin
            first_len = $urandom_range(1, 61);
            send_byte(ByteW'(first_len));
            send_label(first_len);
            // 63 - first_len fills the name to the limit, one more overflows
            send_byte(ByteW'(63 - first_len + $urandom_range(0, 1)));
            if (lbl_open) begin
                send_label(lbl_left);
                send_byte('0);
            end
        end
        go_idle();
        wait_for_drain();
    endtask

    task automatic test_phase(input int unsigned send_pct, input int unsigned stall_pct,
                              input int unsigned n_items);
        send_idle_pct = send_pct;
        rx_stall_pct  = stall_pct;
        run_random(n_items);
        go_idle();
        wait_for_drain();
    endtask

    // Receiver holds off for a long stretch while names keep coming,
    // so the pipe fills and tready drops on the slave side.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        fork
            begin
                @(negedge clk);
                rx_hold = 1'b1;
                repeat (300) @(negedge clk);
                rx_hold = 1'b0;
            end
            run_random(60);
        join
        go_idle();
        wait_for_drain();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_length_limit();
        test_phase(0, 0, 150);
        test_phase(87, 0, 150);
        test_phase(0, 87, 150);
        test_phase(7, 7, 150);
        test_backpressure();

        rx_stall_pct = 0;
        wait_for_drain();
        repeat (Latency + 8) @(posedge clk);

        $display("Sent %0d name bytes, checked %0d results: %0d characters, %0d name ends, %0d overflows.",
                 items_sent, results_seen, n_chars, n_ends, n_errors);
        $display("Covered free flow, sender gaps, receiver stalls, a long hold-off and the length limit.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dnld_pkg.sv
rtl/core/dnld_in_reg.sv
rtl/core/dnld_decode.sv
rtl/core/dnld_out_reg.sv
rtl/core/dns_name_label_decoder.sv
rtl/core/dnld_checker.sv
tb/sv/dns_name_label_decoder_test.sv
